FILE: hdl/nfpa_pkg.sv
// ----------------------------------------------------------------------------
// nfpa_pkg
// Shared sizes, codes and types of the next-fit page allocator.
// ----------------------------------------------------------------------------
package nfpa_pkg;

	localparam int SLAB_COUNT     = 4;
	localparam int PAGES_PER_SLAB = 256;
	localparam int TOTAL_PAGES    = SLAB_COUNT * PAGES_PER_SLAB;

	// Field widths of the request and response items.
	localparam int SLAB_W = 2;
	localparam int PAGE_W = 8;

	// The bitmap is kept as words of WORD_W page marks.
	localparam int WORD_W     = 32;
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int WORD_COUNT = (TOTAL_PAGES + WORD_W - 1) / WORD_W;
	localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int LIN_W      = ADDR_W + BIT_W;
	localparam int SCAN_W     = $clog2(WORD_COUNT + 2);

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic STAT_OK      = 1'b0;
	localparam logic STAT_NO_FREE = 1'b1;

	typedef struct packed {
		logic              action;
		logic [SLAB_W-1:0] free_slab;
		logic [PAGE_W-1:0] free_page;
		logic              last;
	} nfpa_req_t;

	typedef struct packed {
		logic              status;
		logic [SLAB_W-1:0] grant_slab;
		logic [PAGE_W-1:0] grant_page;
	} nfpa_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FREE_RD,
		ST_FREE_WR,
		ST_REPLY
	} nfpa_state_t;

	typedef struct packed {
		logic latch;
		logic scan_start;
		logic scan;
		logic free_rd;
		logic free_wr;
		logic load_rsp;
	} nfpa_cmd_t;

	typedef struct packed {
		logic found;
		logic exhausted;
		logic last;
		logic rsp_busy;
	} nfpa_sts_t;

endpackage

FILE: hdl/nfpa_ram.sv
// ----------------------------------------------------------------------------
// nfpa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nfpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/nfpa_ctrl.sv
// ----------------------------------------------------------------------------
// nfpa_ctrl
// Sequencer of the allocator: scan, free read-modify-write and reply.
// ----------------------------------------------------------------------------
module nfpa_ctrl import nfpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_action,
	output logic      req_stall,
	output nfpa_cmd_t cmd,
	input  nfpa_sts_t sts
);

	nfpa_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (req_action == ACT_ALLOC) ? ST_SCAN : ST_FREE_RD;
				end
			end
			ST_SCAN: begin
				if (sts.found || sts.exhausted) begin
					state_d = ST_REPLY;
				end
			end
			ST_FREE_RD: begin
				state_d = ST_FREE_WR;
			end
			ST_FREE_WR: begin
				state_d = sts.last ? ST_REPLY : ST_IDLE;
			end
			ST_REPLY: begin
				if (!sts.rsp_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall      = (state_q != ST_IDLE);
		cmd.latch      = (state_q == ST_IDLE) && req_valid;
		cmd.scan_start = (state_q == ST_IDLE) && req_valid && (req_action == ACT_ALLOC);
		cmd.scan       = (state_q == ST_SCAN);
		cmd.free_rd    = (state_q == ST_FREE_RD);
		cmd.free_wr    = (state_q == ST_FREE_WR);
		cmd.load_rsp   = (state_q == ST_REPLY) && !sts.rsp_busy;
	end

endmodule

FILE: hdl/nfpa_dp.sv
// ----------------------------------------------------------------------------
// nfpa_dp
// Datapath: page bitmap RAM, row valid bits, cursor, word scan and response.
// ----------------------------------------------------------------------------
module nfpa_dp import nfpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  nfpa_req_t req,
	input  nfpa_cmd_t cmd,
	output nfpa_sts_t sts,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output nfpa_rsp_t rsp
);

	nfpa_req_t             req_q;
	logic [LIN_W-1:0]      cursor_q;
	logic [SCAN_W-1:0]     scan_k_q;
	logic                  rd_vld_s1;
	logic [SCAN_W-1:0]     rd_k_s1;
	logic [ADDR_W-1:0]     rd_addr_s1;
	logic [WORD_COUNT-1:0] row_vld_q;
	nfpa_rsp_t             res_q;
	logic                  rsp_valid_q;
	nfpa_rsp_t             rsp_q;

	logic [ADDR_W-1:0] start_word;
	logic [BIT_W-1:0]  start_bit;
	logic [ADDR_W+1:0] scan_sum;
	logic [ADDR_W-1:0] scan_addr;
	logic              k_done;
	logic              issue;
	logic [LIN_W-1:0]  free_lin;
	logic              free_ok;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;
	logic [WORD_W-1:0] range_mask;
	logic [WORD_W-1:0] k_mask;
	logic [WORD_W-1:0] word_eff;
	logic [WORD_W-1:0] cand;
	logic [WORD_W-1:0] onehot;
	logic [BIT_W-1:0]  bitpos;
	logic              any_free;
	logic [LIN_W-1:0]  found_lin;
	logic              scan_wr;
	logic              free_wr;
	logic              ram_we;
	logic [WORD_W-1:0] ram_wdata;

	assign start_word = cursor_q[LIN_W-1:BIT_W];
	assign start_bit  = cursor_q[BIT_W-1:0];

	// Word k of the scan sits k words after the cursor word, wrapping once.
	assign scan_sum  = (ADDR_W+2)'(start_word) + (ADDR_W+2)'(scan_k_q);
	assign scan_addr = (scan_sum >= (ADDR_W+2)'(WORD_COUNT))
		? ADDR_W'(scan_sum - (ADDR_W+2)'(WORD_COUNT)) : ADDR_W'(scan_sum);
	assign k_done    = (scan_k_q > SCAN_W'(WORD_COUNT));
	assign issue     = cmd.scan && !k_done;

	assign free_lin = LIN_W'(int'(req_q.free_slab) * PAGES_PER_SLAB + int'(req_q.free_page));
	assign free_ok  = (int'(req_q.free_slab) < SLAB_COUNT)
		&& (int'(req_q.free_page) < PAGES_PER_SLAB);

	assign ram_raddr = cmd.free_rd ? free_lin[LIN_W-1:BIT_W] : scan_addr;

	nfpa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WORD_COUNT)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (rd_addr_s1),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The first scanned word only counts marks from the cursor on, and the
	// final revisit of that word only the marks below the cursor.
	always_comb begin
		for (int b = 0; b < WORD_W; b++) begin
			range_mask[b] = (int'({rd_addr_s1, BIT_W'(b)}) < TOTAL_PAGES);
			if (rd_k_s1 == '0) begin
				k_mask[b] = (BIT_W'(b) >= start_bit);
			end else if (rd_k_s1 == SCAN_W'(WORD_COUNT)) begin
				k_mask[b] = (BIT_W'(b) < start_bit);
			end else begin
				k_mask[b] = 1'b1;
			end
		end
	end

	// A row never written since reset reads as all pages free.
	assign word_eff = (ram_rdata & {WORD_W{row_vld_q[rd_addr_s1]}}) | ~range_mask;
	assign cand     = ~word_eff & k_mask;
	assign onehot   = cand & (~cand + WORD_W'(1));
	assign any_free = |cand;

	always_comb begin
		bitpos = '0;
		for (int b = 0; b < WORD_W; b++) begin
			if (onehot[b]) begin
				bitpos = bitpos | BIT_W'(b);
			end
		end
	end

	assign found_lin = {rd_addr_s1, bitpos};

	assign sts.found     = rd_vld_s1 && any_free;
	assign sts.exhausted = rd_vld_s1 && (rd_k_s1 == SCAN_W'(WORD_COUNT)) && !any_free;
	assign sts.last      = req_q.last;
	assign sts.rsp_busy  = rsp_valid_q && rsp_stall;

	assign scan_wr   = cmd.scan && sts.found;
	assign free_wr   = cmd.free_wr && free_ok;
	assign ram_we    = scan_wr || free_wr;
	assign ram_wdata = scan_wr ? (word_eff | onehot)
		: (word_eff & ~(WORD_W'(1) << free_lin[BIT_W-1:0]));

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req;
		end
		rd_k_s1    <= scan_k_q;
		rd_addr_s1 <= ram_raddr;
		if (scan_wr) begin
			res_q.status     <= STAT_OK;
			res_q.grant_slab <= SLAB_W'(found_lin / PAGES_PER_SLAB);
			res_q.grant_page <= PAGE_W'(found_lin % PAGES_PER_SLAB);
		end else if (cmd.scan && sts.exhausted) begin
			res_q <= '{status: STAT_NO_FREE, grant_slab: '0, grant_page: '0};
		end else if (cmd.free_wr && req_q.last) begin
			res_q <= '{status: STAT_OK, grant_slab: '0, grant_page: '0};
		end
		if (cmd.load_rsp) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			scan_k_q    <= '0;
			rd_vld_s1   <= 1'b0;
			row_vld_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				scan_k_q <= '0;
			end else if (issue) begin
				scan_k_q <= scan_k_q + SCAN_W'(1);
			end
			rd_vld_s1 <= issue;
			if (scan_wr) begin
				cursor_q <= found_lin;
			end
			if (ram_we) begin
				row_vld_q[rd_addr_s1] <= 1'b1;
			end
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_rsp |-> !(rsp_valid_q && rsp_stall))
		else $error("response loaded over a stalled response");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_rsp |=> rsp_valid_q)
		else $error("loaded response not presented");

	assert property (@(posedge clk) disable iff (!arst_n)
		int'(cursor_q) < TOTAL_PAGES)
		else $error("cursor beyond the last page");

	assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (rd_k_s1 <= SCAN_W'(WORD_COUNT)))
		else $error("scan read past the wrap-around word");

endmodule

FILE: hdl/next_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_page_allocator
// Next-fit page allocator over a bitmap of page marks across all slabs.
// ----------------------------------------------------------------------------
// Usage: requests enter on req/req_valid and are taken at an edge where
// req_valid is high and req_stall is low. An allocate item scans the bitmap
// from the cursor page, wrapping once, and returns the first free page found
// (or status no free page). A free item clears one page mark; only a free
// item with last set gives a reply, with status success.
// Responses leave on rsp/rsp_valid and are taken when rsp_stall is low. The
// response register holds a result while the receiver stalls, and the block
// goes on taking new items; a further result waits until the register frees.
// Timing: the bitmap RAM gives one 32-page word per cycle through its single
// read port, so an allocate reads words from the cursor word on until it finds
// a free page, and when none is free reads every word and the cursor word once
// more. A free reads the word of its page and writes it back, then replies if
// last is set. One item is in work at a time.
// Reset: all pages read as free at once (per-row valid bits), and the cursor
// points at slab 0, page 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
module next_fit_page_allocator import nfpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  nfpa_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output nfpa_rsp_t rsp
);

	nfpa_cmd_t cmd;
	nfpa_sts_t sts;

	nfpa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req.action),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	nfpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
